### design/ts_sec_pkg.sv
// Shared types, constants and the CRC32 byte update for the TS section extractor.
`timescale 1ns / 1ps
`default_nettype none
package ts_sec_pkg;

    // Packet framing
    localparam int PACKET_BYTES      = 188;
    localparam int SECTION_MAX_BYTES = 4096;
    localparam int POS_W             = 8;
    localparam int SIZE_W            = 13;

    localparam logic [7:0]        SYNC_BYTE    = 8'h47;
    localparam logic [POS_W-1:0]  PACKET_LAST  = POS_W'(PACKET_BYTES);
    localparam logic [POS_W-1:0]  PAYLOAD_END  = 8'd188;
    localparam logic [9:0]        OFFSET_LIMIT = 10'd180;
    localparam logic [8:0]        START_CAP    = 9'd183;
    localparam logic [SIZE_W-1:0] SIZE_MAX     = SIZE_W'(SECTION_MAX_BYTES);

    // Header flag bits
    localparam logic [7:0] F_PUSI     = 8'h01;
    localparam logic [7:0] F_AFL_WAIT = 8'h02;
    localparam logic [7:0] F_PTR      = 8'h04;
    localparam logic [7:0] F_STARTED  = 8'h08;

    // Configuration register indexes
    localparam logic CFG_PID_FILTER = 1'b0;
    localparam logic CFG_TABLE_ID   = 1'b1;

    localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // One result word
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       crc_ok;
    } t_result;

    // MPEG-2 CRC32, one byte, MSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h0};
        for (int i = 0; i < 8; i++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### design/ts_sec_core.sv
// Per-byte packet parser, section tracker and CRC update.
`timescale 1ns / 1ps
`default_nettype none
module ts_sec_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [7:0]          i_data_byte,
    input  wire logic                i_packet_start,
    input  wire logic [12:0]         i_pid_filter,
    input  wire logic [7:0]          i_table_id,
    output ts_sec_pkg::t_result      o_result
);

    logic [ts_sec_pkg::POS_W-1:0]  r_pos, n_pos;
    logic                          r_acc, n_acc;
    logic [7:0]                    r_flags, n_flags;
    logic [ts_sec_pkg::POS_W-1:0]  r_off, n_off;
    logic                          r_active, n_active;
    logic [ts_sec_pkg::SIZE_W-1:0] r_size, n_size;
    logic [ts_sec_pkg::SIZE_W-1:0] r_taken, n_taken;
    logic [31:0]                   r_crc, n_crc;

    logic [ts_sec_pkg::POS_W-1:0]  pos;
    logic [12:0]                   pid;
    logic [8:0]                    afl_off;
    logic [9:0]                    ptr_off;
    logic [8:0]                    cap_pos;
    logic [ts_sec_pkg::SIZE_W-1:0] len_sz;
    logic [31:0]                   crc_upd;
    logic                          last;
    ts_sec_pkg::t_result           res;

    // Position in packet, saturating at the packet length
    always_comb begin
        if (i_packet_start) begin
            pos = '0;
        end else if (r_pos >= ts_sec_pkg::PACKET_LAST) begin
            pos = ts_sec_pkg::PACKET_LAST;
        end else begin
            pos = r_pos + 1'b1;
        end
    end

    assign pid     = {r_flags[4:0], i_data_byte};
    assign afl_off = 9'd5 + {1'b0, i_data_byte};
    assign ptr_off = {2'b00, pos} + 10'd1 + {2'b00, i_data_byte};
    assign cap_pos = {1'b0, r_off} + ts_sec_pkg::START_CAP;
    assign len_sz  = {1'b0, r_size[11:8], i_data_byte} + 13'd3;
    assign crc_upd = ts_sec_pkg::crc_byte(r_crc, i_data_byte);

    // Next state and result for one byte
    always_comb begin
        n_pos    = r_pos;
        n_acc    = r_acc;
        n_flags  = r_flags;
        n_off    = r_off;
        n_active = r_active;
        n_size   = r_size;
        n_taken  = r_taken;
        n_crc    = r_crc;
        last     = 1'b0;
        res      = '0;
        if (i_accept) begin
            n_pos = pos;
            if (pos == '0) begin
                n_acc   = (i_data_byte == ts_sec_pkg::SYNC_BYTE);
                n_flags = '0;
                n_off   = '0;
            end else if (r_acc) begin
                if (pos == 8'd1) begin
                    n_flags = i_data_byte;
                end else if (pos == 8'd2) begin
                    if (pid != i_pid_filter) begin
                        n_acc = 1'b0;
                    end
                    n_flags = r_flags[6] ? ts_sec_pkg::F_PUSI : 8'h00;
                end else if (pos == 8'd3) begin
                    if (i_data_byte[5]) begin
                        n_flags = r_flags | ts_sec_pkg::F_AFL_WAIT;
                    end else begin
                        n_off = 8'd4;
                        if ((r_flags & ts_sec_pkg::F_PUSI) != '0) begin
                            n_flags = r_flags | ts_sec_pkg::F_PTR;
                        end
                    end
                end else if ((r_flags & ts_sec_pkg::F_AFL_WAIT) != '0) begin
                    // adaptation field length byte
                    n_flags = r_flags & ~ts_sec_pkg::F_AFL_WAIT;
                    if ((r_flags & ts_sec_pkg::F_PUSI) != '0) begin
                        if ({1'b0, afl_off} >= ts_sec_pkg::OFFSET_LIMIT) begin
                            n_acc = 1'b0;
                        end else begin
                            n_flags = (r_flags & ~ts_sec_pkg::F_AFL_WAIT) | ts_sec_pkg::F_PTR;
                            n_off   = afl_off[7:0];
                        end
                    end else begin
                        n_off = afl_off[8] ? 8'hFF : afl_off[7:0];
                    end
                end else if (pos < r_off || pos >= ts_sec_pkg::PAYLOAD_END) begin
                    // outside payload
                end else if ((r_flags & ts_sec_pkg::F_PTR) != '0) begin
                    // pointer field
                    if (pos == r_off) begin
                        if (ptr_off >= ts_sec_pkg::OFFSET_LIMIT) begin
                            n_acc = 1'b0;
                        end else begin
                            n_off   = ptr_off[7:0];
                            n_flags = r_flags & ~ts_sec_pkg::F_PTR;
                        end
                    end
                end else if (!r_active) begin
                    // look for the table id
                    if (pos == r_off && i_data_byte == i_table_id) begin
                        n_active   = 1'b1;
                        n_flags    = r_flags | ts_sec_pkg::F_STARTED;
                        n_size     = '0;
                        n_taken    = 13'd1;
                        n_crc      = ts_sec_pkg::crc_byte(ts_sec_pkg::CRC_INIT, i_data_byte);
                        res.valid  = 1'b1;
                        res.data   = i_data_byte;
                        res.first  = 1'b1;
                    end
                end else if ((r_flags & ts_sec_pkg::F_STARTED) != '0 &&
                             {1'b0, pos} >= cap_pos) begin
                    // starting packet cap reached
                end else begin
                    // section body byte
                    n_crc = crc_upd;
                    if (r_taken == 13'd1) begin
                        n_size = {1'b0, i_data_byte[3:0], 8'h00};
                    end else if (r_taken == 13'd2) begin
                        n_size = (len_sz > ts_sec_pkg::SIZE_MAX) ? ts_sec_pkg::SIZE_MAX : len_sz;
                    end
                    n_taken    = r_taken + 1'b1;
                    last       = (r_taken >= 13'd2) && (n_taken >= n_size);
                    res.valid  = 1'b1;
                    res.data   = i_data_byte;
                    res.last   = last;
                    res.crc_ok = last && (crc_upd == '0);
                    if (last) begin
                        n_active = 1'b0;
                        n_acc    = 1'b0;
                    end
                end
            end
        end
    end

    assign o_result = res;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_acc    <= 1'b0;
            r_flags  <= '0;
            r_off    <= '0;
            r_active <= 1'b0;
            r_size   <= '0;
            r_taken  <= '0;
            r_crc    <= ts_sec_pkg::CRC_INIT;
        end else begin
            r_pos    <= n_pos;
            r_acc    <= n_acc;
            r_flags  <= n_flags;
            r_off    <= n_off;
            r_active <= n_active;
            r_size   <= n_size;
            r_taken  <= n_taken;
            r_crc    <= n_crc;
        end
    end

    // A good CRC verdict only rides on a closing word
    a_crc_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.crc_ok |-> res.last)
        else $error("crc_ok without last_of_section");

    // A section only opens when none is in progress, and it is open afterwards
    a_first_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.first |-> (!r_active ##1 r_active))
        else $error("section start while a section is active");

    // Byte count never exceeds the clamp, nor position the packet, while a section is open
    a_taken_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_taken <= ts_sec_pkg::SIZE_MAX && r_pos <= ts_sec_pkg::PACKET_LAST))
        else $error("section byte count or packet position out of range");

endmodule
`default_nettype wire

### design/ts_sec_obuf.sv
// Output register with skid stage for the section byte channel.
`timescale 1ns / 1ps
`default_nettype none
module ts_sec_obuf (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ts_sec_pkg::t_result i_result,
    output logic                     o_can_take,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [7:0]               o_section_byte,
    output logic                     o_first_of_section,
    output logic                     o_last_of_section,
    output logic                     o_crc_ok
);

    ts_sec_pkg::t_result r_out;
    ts_sec_pkg::t_result r_skid;
    logic                r_out_valid;
    logic                r_skid_valid;
    logic                out_free;

    assign out_free   = !r_out_valid || i_ready;
    assign o_can_take = !r_skid_valid;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_result.valid;
            r_skid_valid <= 1'b0;
        end else if (i_result.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_result.valid) begin
            r_skid <= i_result;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_section_byte     = r_out.data;
    assign o_first_of_section = r_out.first;
    assign o_last_of_section  = r_out.last;
    assign o_crc_ok           = r_out.crc_ok;

    // Skid word never exists without an output word ahead of it
    a_skid_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word without output word");

    // A word arriving into a stalled full output goes to the skid stage
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready && i_result.valid) |=> r_skid_valid)
        else $error("word lost on stall");

endmodule
`default_nettype wire

### design/ts_section_extractor_top.sv
// Top level of the transport stream PSI section extractor.
// Usage:
//   Input channel (i_valid / o_ready) carries one stream byte per word with
//   i_packet_start marking the first byte of each 188-byte packet. Packets
//   with sync 0x47 and the configured PID are parsed; adaptation field and
//   pointer field are skipped, and the section starting with the configured
//   table id is passed out byte by byte.
//   Output channel (o_valid / i_ready) carries one section byte per word, with
//   first/last markers and, on the last byte, the CRC32 verdict.
//   Config channel (i_cfg_valid / o_cfg_ready) writes pid_filter (index 0) or
//   table_id (index 1); it is always ready. The user must use it only while
//   idle; the block does not enforce this. Throughput: one input byte per
//   cycle while o_ready is high, set by the per-byte parser and CRC byte
//   update. Section bytes are registered in the output or skid register.
//   Stall: a two-word output stage (register plus skid) holds results; o_ready
//   drops only when both are occupied.
//   Reset: synchronous active low; clears parser state, the CRC to all ones,
//   both config registers to zero and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module ts_section_extractor_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_packet_start,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_section_byte,
    output logic             o_first_of_section,
    output logic             o_last_of_section,
    output logic             o_crc_ok,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [12:0] i_cfg_data
);

    logic [12:0]         r_pid_filter;
    logic [7:0]          r_table_id;
    logic                in_accept;
    logic                can_take;
    ts_sec_pkg::t_result result;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = can_take;
    assign in_accept   = i_valid && can_take;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pid_filter <= '0;
            r_table_id   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ts_sec_pkg::CFG_PID_FILTER: r_pid_filter <= i_cfg_data;
                ts_sec_pkg::CFG_TABLE_ID:   r_table_id   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    ts_sec_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_data_byte    (i_data_byte),
        .i_packet_start (i_packet_start),
        .i_pid_filter   (r_pid_filter),
        .i_table_id     (r_table_id),
        .o_result       (result)
    );

    ts_sec_obuf u_obuf (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_result           (result),
        .o_can_take         (can_take),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_section_byte     (o_section_byte),
        .o_first_of_section (o_first_of_section),
        .o_last_of_section  (o_last_of_section),
        .o_crc_ok           (o_crc_ok)
    );

endmodule
`default_nettype wire

### bench/ts_section_extractor_top_tb.sv
// Self-checking bench for the TS section extractor: random TS packets, byte predictor, scoreboard.
`timescale 1ns / 1ps

// One expected output word
typedef struct packed {
    logic [7:0] data;
    logic       is_first;
    logic       is_last;
    logic       crc_ok;
} t_section_word;

// MPEG-2 CRC32 over one byte, MSB first, no reflection
function automatic logic [31:0] crc32_next(logic [31:0] c, logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
        fb = c[31] ^ d[i];
        c  = {c[30:0], 1'b0};
        if (fb) c = c ^ 32'h04C1_1DB7;
    end
    return c;
endfunction

// Section predictor plus in-order scoreboard of the section bytes still due
class section_scoreboard;
    logic [12:0]   pid_sel;
    logic [7:0]    table_sel;
    int            pkt_pos;
    bit            pkt_ok;
    logic [7:0]    hdr_byte;
    bit            pusi;
    bit            afl_wait;
    bit            ptr_wait;
    bit            started;
    int            pay_off;
    bit            in_section;
    int            sec_size;
    int            taken;
    logic [31:0]   crc;
    t_section_word awaited_bytes[$];
    int            errors;

    function new();
        pid_sel    = '0;
        table_sel  = '0;
        pkt_pos    = 0;
        pkt_ok     = 1'b0;
        hdr_byte   = '0;
        pusi       = 1'b0;
        afl_wait   = 1'b0;
        ptr_wait   = 1'b0;
        started    = 1'b0;
        pay_off    = 0;
        in_section = 1'b0;
        sec_size   = 0;
        taken      = 0;
        crc        = 32'hFFFF_FFFF;
        errors     = 0;
    endfunction

    function void apply_reg(logic idx, logic [12:0] val);
        if (idx == ts_sec_pkg::CFG_PID_FILTER) pid_sel = val;
        else table_sel = val[7:0];
    endfunction

    function int outstanding();
        return awaited_bytes.size();
    endfunction

    // Accepted stream byte: advance the parser, queue a section byte if one results
    function void take_stream_byte(logic [7:0] b, logic ps);
        int            p;
        int            off;
        int            idx;
        bit            lst;
        t_section_word w;
        if (ps) p = 0;
        else begin
            p = pkt_pos + 1;
            if (p > ts_sec_pkg::PACKET_BYTES) p = ts_sec_pkg::PACKET_BYTES;
        end
        pkt_pos = p;

        // header: sync, PID, adaptation control
        if (p == 0) begin
            pkt_ok   = (b == ts_sec_pkg::SYNC_BYTE);
            pusi     = 1'b0;
            afl_wait = 1'b0;
            ptr_wait = 1'b0;
            started  = 1'b0;
            pay_off  = 0;
            return;
        end
        if (!pkt_ok) return;
        if (p == 1) begin
            hdr_byte = b;
            return;
        end
        if (p == 2) begin
            if ({hdr_byte[4:0], b} != pid_sel) pkt_ok = 1'b0;
            pusi     = hdr_byte[6];
            afl_wait = 1'b0;
            ptr_wait = 1'b0;
            started  = 1'b0;
            return;
        end
        if (p == 3) begin
            if (b[5]) afl_wait = 1'b1;
            else begin
                pay_off  = 4;
                ptr_wait = pusi;
            end
            return;
        end

        // adaptation field length
        if (afl_wait) begin
            off      = 5 + b;
            afl_wait = 1'b0;
            if (pusi) begin
                if (off >= int'(ts_sec_pkg::OFFSET_LIMIT)) begin
                    pkt_ok = 1'b0;
                    return;
                end
                ptr_wait = 1'b1;
            end
            pay_off = (off > 255) ? 255 : off;
            return;
        end
        if (p < pay_off || p >= int'(ts_sec_pkg::PAYLOAD_END)) return;

        // pointer field on unit start
        if (ptr_wait) begin
            if (p != pay_off) return;
            off = p + 1 + b;
            if (off >= int'(ts_sec_pkg::OFFSET_LIMIT)) begin
                pkt_ok = 1'b0;
                return;
            end
            pay_off  = off;
            ptr_wait = 1'b0;
            return;
        end

        // section start on the table id byte
        if (!in_section) begin
            if (p != pay_off || b != table_sel) return;
            in_section = 1'b1;
            started    = 1'b1;
            sec_size   = 0;
            taken      = 1;
            crc        = crc32_next(32'hFFFF_FFFF, b);
            w.data     = b;
            w.is_first = 1'b1;
            w.is_last  = 1'b0;
            w.crc_ok   = 1'b0;
            awaited_bytes.push_back(w);
            return;
        end
        if (started && p >= pay_off + int'(ts_sec_pkg::START_CAP)) return;

        // section body; length from bytes 1 and 2, clamped
        idx = taken;
        crc = crc32_next(crc, b);
        if (idx == 1) sec_size = int'(b[3:0]) << 8;
        else if (idx == 2) begin
            sec_size = ((sec_size | int'(b)) & 'hfff) + 3;
            if (sec_size > ts_sec_pkg::SECTION_MAX_BYTES)
                sec_size = ts_sec_pkg::SECTION_MAX_BYTES;
        end
        taken      = (idx + 1) & 'h1fff;
        lst        = (idx >= 2) && (taken >= sec_size);
        w.data     = b;
        w.is_first = 1'b0;
        w.is_last  = lst;
        w.crc_ok   = lst && (crc == 32'h0);
        awaited_bytes.push_back(w);
        if (lst) begin
            in_section = 1'b0;
            pkt_ok     = 1'b0;
        end
    endfunction

    // Output word: compare against the oldest predicted byte
    function void check_section_byte(logic [7:0] d, logic f, logic l, logic ok);
        t_section_word w;
        if (awaited_bytes.size() == 0) begin
            $error("section_byte %0h arrived with nothing predicted", d);
            errors++;
            return;
        end
        w = awaited_bytes.pop_front();
        if (d !== w.data) begin
            $error("section_byte: expected %0h, got %0h", w.data, d);
            errors++;
        end
        if (f !== w.is_first) begin
            $error("first_of_section: expected %0b, got %0b", w.is_first, f);
            errors++;
        end
        if (l !== w.is_last) begin
            $error("last_of_section: expected %0b, got %0b", w.is_last, l);
            errors++;
        end
        if (ok !== w.crc_ok) begin
            $error("crc_ok: expected %0b, got %0b", w.crc_ok, ok);
            errors++;
        end
    endfunction
endclass

module ts_section_extractor_top_tb;

    localparam int CYCLE_LIMIT  = 500_000;
    localparam int PHASE_BYTES  = 360;
    localparam int SETTLE_CYC   = 4;
    localparam int HOLD_CYC     = 300;

    // Leading stray bytes, a 3-byte section, AF and pointer overruns, bad sync.
    // Bit 8 is packet_start.
    localparam logic [8:0] DIRECTED_BYTES [25] = '{
        9'h047, 9'h0ff,
        9'h147, 9'h0df, 9'h0ff, 9'h010, 9'h000, 9'h000, 9'h0f0, 9'h000, 9'h0ff,
        9'h147, 9'h0df, 9'h0ff, 9'h030, 9'h0b0, 9'h000,
        9'h146, 9'h01f, 9'h0ff,
        9'h147, 9'h05f, 9'h0ff, 9'h010, 9'h0b3
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_packet_start;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_section_byte;
    logic        o_first_of_section;
    logic        o_last_of_section;
    logic        o_crc_ok;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [12:0] i_cfg_data;

    section_scoreboard sb;
    logic [7:0]        sec_q[$];
    logic [7:0]        pkt_q[$];
    int                send_idle;
    int                recv_idle;
    int                hold_left;
    int                cycle_cnt;

    ts_section_extractor_top DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_data_byte        (i_data_byte),
        .i_packet_start     (i_packet_start),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_section_byte     (o_section_byte),
        .o_first_of_section (o_first_of_section),
        .o_last_of_section  (o_last_of_section),
        .o_crc_ok           (o_crc_ok),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: random back-pressure, or a long hold when requested
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_ready   = 1'b0;
                hold_left = hold_left - 1;
            end else begin
                i_ready = ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // Check every output word taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_section_byte(o_section_byte, o_first_of_section,
                                  o_last_of_section, o_crc_ok);
    end

    // Offer one stream word; returns once it is taken
    task automatic send_byte(logic [7:0] b, logic ps);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_data_byte    = b;
        i_packet_start = ps;
        do @(posedge i_clk); while (!o_ready);
        sb.take_stream_byte(b, ps);
    endtask

    task automatic send_packet();
        foreach (pkt_q[i]) send_byte(pkt_q[i], i == 0);
    endtask

    task automatic write_reg(logic idx, logic [12:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.apply_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Stop sending and let every predicted byte drain out
    task automatic settle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Build the next section to carry; a clean one always matches and fits one packet
    function automatic void new_section(bit clean_one);
        logic [31:0] c;
        logic [11:0] len;
        logic [7:0]  tid;
        int          n;
        int          r;
        r = $urandom_range(99);
        if (clean_one) len = 12'($urandom_range(20, 120));
        else if (r < 5) len = 12'($urandom_range(3));
        else if (r < 85) len = 12'($urandom_range(4, 40));
        else len = 12'($urandom_range(41, 300));
        tid = sb.table_sel;
        if (!clean_one && $urandom_range(99) < 8) tid = tid ^ 8'($urandom_range(1, 255));
        n = int'(len) + 3;
        if (n > ts_sec_pkg::SECTION_MAX_BYTES) n = ts_sec_pkg::SECTION_MAX_BYTES;
        sec_q.delete();
        sec_q.push_back(tid);
        sec_q.push_back({4'($urandom_range(15)), len[11:8]});
        sec_q.push_back(len[7:0]);
        if (n < 7) begin
            while (sec_q.size() < n) sec_q.push_back(8'($urandom_range(255)));
        end else begin
            while (sec_q.size() < n - 4) sec_q.push_back(8'($urandom_range(255)));
            c = 32'hFFFF_FFFF;
            foreach (sec_q[i]) c = crc32_next(c, sec_q[i]);
            sec_q.push_back(c[31:24]);
            sec_q.push_back(c[23:16]);
            sec_q.push_back(c[15:8]);
            sec_q.push_back(c[7:0]);
            // broken CRC now and then
            if (!clean_one && $urandom_range(99) < 20)
                sec_q[n - 1 - $urandom_range(3)] ^= 8'(1 << $urandom_range(7));
        end
    endfunction

    // Build one packet into pkt_q; returns its length, or 0 for a stray packet
    function automatic int build_packet(bit clean);
        int          plen;
        int          af_len;
        int          ptr;
        int          pay;
        int          r;
        bit          pusi;
        bit          af;
        bit          carries;
        logic [12:0] pid;
        pkt_q.delete();
        pid = sb.pid_sel;
        r   = $urandom_range(99);

        // bad sync or foreign PID, random content
        if (!clean && r < 10) begin
            plen = $urandom_range(3, 60);
            pkt_q.push_back(r < 5 ? ts_sec_pkg::SYNC_BYTE : 8'($urandom_range(255)));
            while (pkt_q.size() < plen) pkt_q.push_back(8'($urandom_range(255)));
            return 0;
        end

        r = $urandom_range(99);
        if (clean) plen = ts_sec_pkg::PACKET_BYTES;
        else if (r < 65) plen = $urandom_range(8, 60);
        else if (r < 88) plen = ts_sec_pkg::PACKET_BYTES;
        else plen = $urandom_range(150, 204);

        pusi = (sec_q.size() == 0);
        if (pusi) new_section(clean);
        af = !clean && ($urandom_range(99) < 25);
        pkt_q.push_back(ts_sec_pkg::SYNC_BYTE);
        pkt_q.push_back({1'($urandom_range(1)), pusi, 1'($urandom_range(1)), pid[12:8]});
        pkt_q.push_back(pid[7:0]);
        pkt_q.push_back({2'($urandom_range(3)), af, 1'($urandom_range(1)),
                         4'($urandom_range(15))});
        pay     = 4;
        carries = 1'b1;

        // adaptation field, occasionally past the packet
        if (af) begin
            af_len = ($urandom_range(99) < 6) ? $urandom_range(170, 255) : $urandom_range(7);
            pkt_q.push_back(8'(af_len));
            repeat (af_len) pkt_q.push_back(8'($urandom_range(255)));
            pay = 5 + af_len;
            if (pusi && pay >= int'(ts_sec_pkg::OFFSET_LIMIT)) carries = 1'b0;
        end

        // pointer field, occasionally past the limit
        if (pusi && carries) begin
            r   = $urandom_range(99);
            ptr = (!clean && r < 5) ? $urandom_range(170, 255) :
                  (r < 70) ? 0 : $urandom_range(1, 3);
            pkt_q.push_back(8'(ptr));
            repeat (ptr) pkt_q.push_back(8'($urandom_range(255)));
            pay = pay + 1 + ptr;
            if (pay >= int'(ts_sec_pkg::OFFSET_LIMIT)) carries = 1'b0;
        end

        while (pkt_q.size() > plen) void'(pkt_q.pop_back());
        while (pkt_q.size() < plen) begin
            if (carries && pkt_q.size() < int'(ts_sec_pkg::PAYLOAD_END) && sec_q.size() != 0)
                pkt_q.push_back(sec_q.pop_front());
            else
                pkt_q.push_back(8'($urandom_range(255)));
        end
        return plen;
    endfunction

    // Main sequence
    initial begin
        int budget;
        bit paused;
        sb             = new();
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data_byte    = '0;
        i_packet_start = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = ts_sec_pkg::CFG_PID_FILTER;
        i_cfg_data     = '0;
        send_idle      = 0;
        recv_idle      = 0;
        hold_left      = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 13 : (ph == 1) ? 68 : 0;
            recv_idle = (ph == 0) ? 68 : (ph == 1) ? 13 : 0;

            // directed words first, with PID at its top value
            if (ph == 0) begin
                write_reg(ts_sec_pkg::CFG_PID_FILTER, 13'h1fff);
                write_reg(ts_sec_pkg::CFG_TABLE_ID, 13'h0000);
                foreach (DIRECTED_BYTES[i])
                    send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
            end
            settle();
            if (ph == 0) begin
                write_reg(ts_sec_pkg::CFG_PID_FILTER, 13'h0000);
                write_reg(ts_sec_pkg::CFG_TABLE_ID, 13'h00ff);
            end else begin
                write_reg(ts_sec_pkg::CFG_PID_FILTER, 13'($urandom_range(8191)));
                write_reg(ts_sec_pkg::CFG_TABLE_ID, 13'($urandom_range(255)));
            end

            budget = 0;
            paused = 1'b0;
            while (budget < PHASE_BYTES) begin
                budget = budget + build_packet(1'b0);
                send_packet();
                // one full drain mid-phase, in the second phase only
                if (ph == 1 && !paused && budget >= PHASE_BYTES / 2) begin
                    settle();
                    paused = 1'b1;
                end
            end
        end

        // finish the open section, then one clean section under a long hold
        while (sec_q.size() != 0) begin
            void'(build_packet(1'b0));
            send_packet();
        end
        hold_left = HOLD_CYC;
        do begin
            void'(build_packet(1'b1));
            send_packet();
        end while (sec_q.size() != 0);
        settle();

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
design/ts_sec_pkg.sv
design/ts_sec_core.sv
design/ts_sec_obuf.sv
design/ts_section_extractor_top.sv
bench/ts_section_extractor_top_tb.sv
